FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker modules of this core.
// Depends on nothing; include it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/core/rfeu_pkg.sv
// Package of the register file execute unit: sizes, opcodes, state and
// control types shared by the controller, the datapath and the top level.
// Depends on nothing.
`default_nettype none

package rfeu_pkg;

  // Register file size and derived address width.
  localparam int NumRegs = 32;
  localparam int RegAw   = (NumRegs > 1) ? $clog2(NumRegs) : 1;

  // Field widths of the instruction and the result.
  localparam int OpW    = 5;
  localparam int IdxW   = 5;
  localparam int DataW  = 32;

  // The divider produces one quotient bit per step.
  localparam int DivSteps = DataW;
  localparam int DivCntW  = $clog2(DivSteps);

  // Instruction opcodes.
  typedef enum logic [OpW-1:0] {
    OpNop   = 5'd0,
    OpAdd   = 5'd1,
    OpSub   = 5'd2,
    OpMul   = 5'd3,
    OpDiv   = 5'd4,
    OpLi    = 5'd5,
    OpInc   = 5'd6,
    OpDec   = 5'd7,
    OpJump  = 5'd8,
    OpBeq   = 5'd9,
    OpBne   = 5'd10,
    OpBgez  = 5'd11,
    OpBgtz  = 5'd12,
    OpBlez  = 5'd13,
    OpBltz  = 5'd14,
    OpLoad  = 5'd15,
    OpStore = 5'd16,
    OpHalt  = 5'd17
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StRdA,
    StRdB,
    StExec,
    StDiv,
    StFin
  } state_e;

  // One decoded instruction.
  typedef struct packed {
    logic [OpW-1:0]          opcode;
    logic [IdxW-1:0]         dest_reg;
    logic [IdxW-1:0]         src_a_reg;
    logic [IdxW-1:0]         src_b_reg;
    logic signed [DataW-1:0] immediate;
    logic signed [DataW-1:0] load_value;
  } instr_t;

  // One executed result.
  typedef struct packed {
    logic                    reg_write_valid;
    logic [IdxW-1:0]         reg_write_index;
    logic signed [DataW-1:0] reg_write_value;
    logic                    redirect;
    logic [DataW-1:0]        redirect_target;
    logic                    store_valid;
    logic signed [DataW-1:0] store_value;
    logic                    halted;
    logic                    divide_by_zero;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_instr;
    logic rd_second;
    logic cap_a;
    logic cap_b;
    logic div_start;
    logic div_step;
    logic load_result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_go;
    logic out_free;
  } sts_t;

  // True when a register index addresses an existing register.
  function automatic logic reg_idx_ok(logic [IdxW-1:0] idx);
    return int'(idx) < NumRegs;
  endfunction

  // Register file address of a register index.
  function automatic logic [RegAw-1:0] reg_addr(logic [IdxW-1:0] idx);
    return RegAw'(idx);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rfeu_req_if.sv
// Request channel of the execute unit: valid/ready plus instruction fields.
// Depends on rfeu_pkg for the field widths.
`default_nettype none

interface rfeu_req_if;
  logic                              valid;
  logic                              ready;
  logic [rfeu_pkg::OpW-1:0]          opcode;
  logic [rfeu_pkg::IdxW-1:0]         dest_reg;
  logic [rfeu_pkg::IdxW-1:0]         src_a_reg;
  logic [rfeu_pkg::IdxW-1:0]         src_b_reg;
  logic signed [rfeu_pkg::DataW-1:0] immediate;
  logic signed [rfeu_pkg::DataW-1:0] load_value;

  modport source (
    output valid, opcode, dest_reg, src_a_reg, src_b_reg, immediate, load_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, dest_reg, src_a_reg, src_b_reg, immediate, load_value,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/rfeu_rsp_if.sv
// Result channel of the execute unit: valid/ready plus result fields.
// Depends on rfeu_pkg for the field widths.
`default_nettype none

interface rfeu_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              reg_write_valid;
  logic [rfeu_pkg::IdxW-1:0]         reg_write_index;
  logic signed [rfeu_pkg::DataW-1:0] reg_write_value;
  logic                              redirect;
  logic [rfeu_pkg::DataW-1:0]        redirect_target;
  logic                              store_valid;
  logic signed [rfeu_pkg::DataW-1:0] store_value;
  logic                              halted;
  logic                              divide_by_zero;

  modport source (
    output valid, reg_write_valid, reg_write_index, reg_write_value, redirect,
           redirect_target, store_valid, store_value, halted, divide_by_zero,
    input  ready
  );

  modport sink (
    input  valid, reg_write_valid, reg_write_index, reg_write_value, redirect,
           redirect_target, store_valid, store_value, halted, divide_by_zero,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/rfeu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module rfeu_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/rfeu_ctrl.sv
// Controller of the execute unit: sequences register reads, the divider
// and the result hand-off. Depends on rfeu_pkg.
`default_nettype none

module rfeu_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire rfeu_pkg::sts_t sts_i,
  output rfeu_pkg::cmd_t     cmd_o
);

  rfeu_pkg::state_e state_q, state_d;
  logic [rfeu_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic div_last;

  assign div_last = (cnt_q == rfeu_pkg::DivCntW'(rfeu_pkg::DivSteps - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rfeu_pkg::StIdle: begin
        if (req_valid_i) state_d = rfeu_pkg::StRdA;
      end
      rfeu_pkg::StRdA: state_d = rfeu_pkg::StRdB;
      rfeu_pkg::StRdB: state_d = rfeu_pkg::StExec;
      rfeu_pkg::StExec: begin
        state_d = sts_i.div_go ? rfeu_pkg::StDiv : rfeu_pkg::StFin;
      end
      rfeu_pkg::StDiv: begin
        if (div_last) state_d = rfeu_pkg::StFin;
      end
      rfeu_pkg::StFin: begin
        if (sts_i.out_free) state_d = rfeu_pkg::StIdle;
      end
      default: state_d = rfeu_pkg::StIdle;
    endcase
  end

  // Outputs to the datapath and the request channel.
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      rfeu_pkg::StIdle: begin
        req_ready_o         = 1'b1;
        cmd_o.load_instr    = req_valid_i;
      end
      rfeu_pkg::StRdA: cmd_o.rd_second = 1'b0;
      rfeu_pkg::StRdB: begin
        cmd_o.rd_second = 1'b1;
        cmd_o.cap_a     = 1'b1;
      end
      rfeu_pkg::StExec: begin
        cmd_o.cap_b     = 1'b1;
        cmd_o.div_start = sts_i.div_go;
      end
      rfeu_pkg::StDiv: cmd_o.div_step = 1'b1;
      rfeu_pkg::StFin: cmd_o.load_result = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  // Divider step counter.
  always_comb begin
    cnt_d = cnt_q;
    if (state_q == rfeu_pkg::StExec) begin
      cnt_d = '0;
    end else if (state_q == rfeu_pkg::StDiv) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfeu_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rfeu_dp.sv
// Datapath of the execute unit: register file, operand registers, the
// bit-serial divider, the ALU and the result register. Depends on rfeu_pkg
// and rfeu_ram.
`default_nettype none

module rfeu_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rfeu_pkg::instr_t instr_i,
  input  wire rfeu_pkg::cmd_t   cmd_i,
  output rfeu_pkg::sts_t        sts_o,
  input  wire logic             rsp_ready_i,
  output logic                  rsp_valid_o,
  output rfeu_pkg::result_t     result_o
);

  localparam int DW = rfeu_pkg::DataW;

  rfeu_pkg::instr_t  instr_q;
  rfeu_pkg::result_t res_d, res_q;
  logic              rsp_valid_q;

  logic [rfeu_pkg::NumRegs-1:0] written_q;
  logic [rfeu_pkg::IdxW-1:0]    rd_idx;
  logic [rfeu_pkg::RegAw-1:0]   raddr;
  logic [DW-1:0]                rdata;
  logic                         rvld_q;
  logic [DW-1:0]                rval;
  logic [DW-1:0]                a_q, b_q;

  logic [DW-1:0] quo_q, rem_q, mb_q;
  logic          neg_q;
  logic [DW:0]   shifted, diff;
  logic          we;

  // Instruction register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_instr) instr_q <= instr_i;
  end

  // Register file read: source A first, then source B or the destination.
  always_comb begin
    rd_idx = instr_q.src_a_reg;
    if (cmd_i.rd_second) begin
      if (instr_q.opcode == rfeu_pkg::OpInc || instr_q.opcode == rfeu_pkg::OpDec) begin
        rd_idx = instr_q.dest_reg;
      end else begin
        rd_idx = instr_q.src_b_reg;
      end
    end
  end

  assign raddr = rfeu_pkg::reg_addr(rd_idx);

  rfeu_ram #(
    .Width(DW),
    .Depth(rfeu_pkg::NumRegs)
  ) u_regs (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(rfeu_pkg::reg_addr(res_d.reg_write_index)),
    .wdata_i(res_d.reg_write_value),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // A register never written since reset, or out of range, reads as zero.
  always_ff @(posedge clk_i) begin
    rvld_q <= rfeu_pkg::reg_idx_ok(rd_idx) && written_q[raddr];
  end

  assign rval = rvld_q ? rdata : '0;

  // Operand registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) a_q <= rval;
    if (cmd_i.cap_b) b_q <= rval;
  end

  // Valid bits of the register file entries.
  assign we = cmd_i.load_result && res_d.reg_write_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (we) begin
      written_q[rfeu_pkg::reg_addr(res_d.reg_write_index)] <= 1'b1;
    end
  end

  // Restoring divider on magnitudes, one quotient bit per step.
  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, mb_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= a_q[DW-1] ? (DW'(0) - a_q) : a_q;
      mb_q  <= rval[DW-1] ? (DW'(0) - rval) : rval;
      rem_q <= '0;
      neg_q <= a_q[DW-1] ^ rval[DW-1];
    end else if (cmd_i.div_step) begin
      rem_q <= diff[DW] ? shifted[DW-1:0] : diff[DW-1:0];
      quo_q <= {quo_q[DW-2:0], ~diff[DW]};
    end
  end

  assign sts_o.div_go = (instr_q.opcode == rfeu_pkg::OpDiv) && (rval != '0);

  // Result of the instruction.
  always_comb begin
    logic          wr;
    logic          taken;
    logic [DW-1:0] wval;
    wr    = 1'b0;
    taken = 1'b0;
    wval  = '0;
    res_d = '0;
    case (instr_q.opcode)
      rfeu_pkg::OpAdd: begin
        wr = 1'b1; wval = a_q + b_q;
      end
      rfeu_pkg::OpSub: begin
        wr = 1'b1; wval = a_q - b_q;
      end
      rfeu_pkg::OpMul: begin
        wr = 1'b1; wval = a_q * b_q;
      end
      rfeu_pkg::OpDiv: begin
        wr = 1'b1;
        if (b_q == '0) begin
          res_d.divide_by_zero = 1'b1;
        end else begin
          wval = neg_q ? (DW'(0) - quo_q) : quo_q;
        end
      end
      rfeu_pkg::OpLi: begin
        wr = 1'b1; wval = instr_q.immediate;
      end
      rfeu_pkg::OpInc: begin
        wr = 1'b1; wval = b_q + 1'b1;
      end
      rfeu_pkg::OpDec: begin
        wr = 1'b1; wval = b_q - 1'b1;
      end
      rfeu_pkg::OpJump: taken = 1'b1;
      rfeu_pkg::OpBeq:  taken = (a_q == b_q);
      rfeu_pkg::OpBne:  taken = (a_q != b_q);
      rfeu_pkg::OpBgez: taken = ~a_q[DW-1];
      rfeu_pkg::OpBgtz: taken = ~a_q[DW-1] && (a_q != '0);
      rfeu_pkg::OpBlez: taken = a_q[DW-1] || (a_q == '0);
      rfeu_pkg::OpBltz: taken = a_q[DW-1];
      rfeu_pkg::OpLoad: begin
        wr = 1'b1; wval = instr_q.load_value;
      end
      rfeu_pkg::OpStore: begin
        res_d.store_valid = 1'b1;
        res_d.store_value = a_q;
      end
      rfeu_pkg::OpHalt: res_d.halted = 1'b1;
      default: wr = 1'b0;
    endcase

    // A write to a register that does not exist is dropped.
    if (wr && rfeu_pkg::reg_idx_ok(instr_q.dest_reg)) begin
      res_d.reg_write_valid = 1'b1;
      res_d.reg_write_index = instr_q.dest_reg;
      res_d.reg_write_value = wval;
    end
    if (taken) begin
      res_d.redirect        = 1'b1;
      res_d.redirect_target = instr_q.immediate - 1'b1;
    end
  end

  // Output register.
  assign sts_o.out_free = ~rsp_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/register_file_execute_unit_core.sv
// Execute stage of a small RISC machine: each request is one decoded
// instruction run against a 32-entry register file that reads as zero after
// reset, and each request yields exactly one result. Requests are taken one
// at a time. After a request is accepted the controller steps through
// StRdA, StRdB and StExec, then StDiv for a division with a nonzero divisor,
// and StFin, which registers the result once the output register is free.
// The next request can be accepted in the cycle after the result is
// registered. The pace is set by the single read port of the register file
// (operands are fetched one after the other) and by the divider, which makes
// one quotient bit per cycle. A finished result waits in the output register
// while the next request is already being taken. No clearing pass runs after
// reset.
// Depends on rfeu_pkg, rfeu_req_if, rfeu_rsp_if, rfeu_ctrl and rfeu_dp.
`default_nettype none

module register_file_execute_unit_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rfeu_req_if.sink    req_i,
  rfeu_rsp_if.source  rsp_o
);

  rfeu_pkg::instr_t  instr;
  rfeu_pkg::result_t result;
  rfeu_pkg::cmd_t    cmd;
  rfeu_pkg::sts_t    sts;
  logic              ready;
  logic              rsp_valid;

  // Gather the request fields.
  assign instr.opcode     = req_i.opcode;
  assign instr.dest_reg   = req_i.dest_reg;
  assign instr.src_a_reg  = req_i.src_a_reg;
  assign instr.src_b_reg  = req_i.src_b_reg;
  assign instr.immediate  = req_i.immediate;
  assign instr.load_value = req_i.load_value;
  assign req_i.ready      = ready;

  rfeu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rfeu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .instr_i    (instr),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_ready_i(rsp_o.ready),
    .rsp_valid_o(rsp_valid),
    .result_o   (result)
  );

  // Drive the result channel.
  assign rsp_o.valid           = rsp_valid;
  assign rsp_o.reg_write_valid = result.reg_write_valid;
  assign rsp_o.reg_write_index = result.reg_write_index;
  assign rsp_o.reg_write_value = result.reg_write_value;
  assign rsp_o.redirect        = result.redirect;
  assign rsp_o.redirect_target = result.redirect_target;
  assign rsp_o.store_valid     = result.store_valid;
  assign rsp_o.store_value     = result.store_value;
  assign rsp_o.halted          = result.halted;
  assign rsp_o.divide_by_zero  = result.divide_by_zero;

endmodule

`default_nettype wire

FILE: rtl/core/rfeu_checker.sv
// Port-level checker of the execute unit, bound to the top level.
// Depends on rfeu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rfeu_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              req_valid_i,
  input wire logic                              req_ready_i,
  input wire logic                              rsp_valid_i,
  input wire logic                              rsp_ready_i,
  input wire logic                              reg_write_valid_i,
  input wire logic [rfeu_pkg::IdxW-1:0]         reg_write_index_i,
  input wire logic signed [rfeu_pkg::DataW-1:0] reg_write_value_i,
  input wire logic                              redirect_i,
  input wire logic                              store_valid_i,
  input wire logic                              halted_i,
  input wire logic                              divide_by_zero_i
);

  // A stalled result holds its valid and its write fields.
  `ASSERT_RST(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(reg_write_value_i) && $stable(reg_write_index_i), "result changed while stalled")

  // Requests are taken one at a time.
  `ASSERT_RST(a_one_at_a_time, clk_i, rst_ni, req_valid_i && req_ready_i |=> !req_ready_i, "request accepted while busy")

  // An instruction has at most one kind of effect.
  `ASSERT_RST(a_one_effect, clk_i, rst_ni, rsp_valid_i |-> $onehot0({reg_write_valid_i, redirect_i, store_valid_i, halted_i}), "result has several effects")

  // Without a register write the write fields are zero.
  `ASSERT_RST(a_write_zero, clk_i, rst_ni, rsp_valid_i && !reg_write_valid_i |-> reg_write_index_i == '0 && reg_write_value_i == '0, "write fields set without a write")

  // A division by zero writes zero.
  `ASSERT_RST(a_div_zero, clk_i, rst_ni, rsp_valid_i && divide_by_zero_i |-> reg_write_value_i == '0, "division by zero wrote nonzero")

endmodule

bind register_file_execute_unit_core rfeu_checker u_rfeu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .reg_write_valid_i(rsp_o.reg_write_valid),
  .reg_write_index_i(rsp_o.reg_write_index),
  .reg_write_value_i(rsp_o.reg_write_value),
  .redirect_i       (rsp_o.redirect),
  .store_valid_i    (rsp_o.store_valid),
  .halted_i         (rsp_o.halted),
  .divide_by_zero_i (rsp_o.divide_by_zero)
);

`default_nettype wire

FILE: test/register_file_execute_unit_core_tb.sv
// Testbench of the register file execute unit: directed and random instructions
// are checked against a predictor that keeps its own copy of the register file.
// Depends on rfeu_pkg, rfeu_req_if, rfeu_rsp_if and register_file_execute_unit_core.

module register_file_execute_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfeu_pkg::*;

  // Opcodes outside the defined set; the unit treats them as nop.
  localparam logic [OpW-1:0] OpUnusedLow = 5'd18;
  localparam logic [OpW-1:0] OpUnusedTop = 5'd31;

  localparam logic [DataW-1:0] MaxPos = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] MinNeg = 32'h8000_0000;

  localparam int IdlePct     = 26;
  localparam int CalmItems   = 200;
  localparam int RandomItems = 1025;
  localparam int DirectedCnt = 25;

  // Expected results of executed instructions, predicted from a private
  // copy of the register file.
  class exec_scoreboard;
    logic [DataW-1:0] regs [NumRegs];
    result_t          expected_q [$];
    int               errors;
    int               checked;
    int               div_zero_seen;
    int               redirects_seen;
    int               stores_seen;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors         = 0;
      checked        = 0;
      div_zero_seen  = 0;
      redirects_seen = 0;
      stores_seen    = 0;
    endfunction

    function logic [DataW-1:0] read_reg(logic [IdxW-1:0] idx);
      if (int'(idx) >= NumRegs) return '0;
      return regs[idx];
    endfunction

    // Execute one accepted instruction and queue the result it must produce.
    function void note_instr(instr_t ins);
      logic [DataW-1:0] a;
      logic [DataW-1:0] b;
      logic [DataW-1:0] d;
      logic [DataW-1:0] wval;
      logic [DataW-1:0] mag_a;
      logic [DataW-1:0] mag_b;
      logic [DataW-1:0] quot;
      logic             wr;
      logic             taken;
      result_t          res;
      res   = '0;
      a     = read_reg(ins.src_a_reg);
      b     = read_reg(ins.src_b_reg);
      d     = read_reg(ins.dest_reg);
      wval  = '0;
      wr    = 1'b0;
      taken = 1'b0;
      case (ins.opcode)
        OpAdd: begin wr = 1'b1; wval = a + b; end
        OpSub: begin wr = 1'b1; wval = a - b; end
        OpMul: begin wr = 1'b1; wval = a * b; end
        OpDiv: begin
          wr = 1'b1;
          if (b == '0) begin
            res.divide_by_zero = 1'b1;
          end else begin
            // Divide magnitudes, then fix the sign; truncates toward zero.
            mag_a = a[DataW-1] ? -a : a;
            mag_b = b[DataW-1] ? -b : b;
            quot  = mag_a / mag_b;
            wval  = (a[DataW-1] != b[DataW-1]) ? -quot : quot;
          end
        end
        OpLi:    begin wr = 1'b1; wval = ins.immediate; end
        OpInc:   begin wr = 1'b1; wval = d + 1; end
        OpDec:   begin wr = 1'b1; wval = d - 1; end
        OpJump:  taken = 1'b1;
        OpBeq:   taken = (a == b);
        OpBne:   taken = (a != b);
        OpBgez:  taken = !a[DataW-1];
        OpBgtz:  taken = !a[DataW-1] && (a != '0);
        OpBlez:  taken = a[DataW-1] || (a == '0);
        OpBltz:  taken = a[DataW-1];
        OpLoad:  begin wr = 1'b1; wval = ins.load_value; end
        OpStore: begin res.store_valid = 1'b1; res.store_value = a; end
        OpHalt:  res.halted = 1'b1;
        default: ;
      endcase
      if (wr && int'(ins.dest_reg) < NumRegs) begin
        regs[ins.dest_reg]    = wval;
        res.reg_write_valid   = 1'b1;
        res.reg_write_index   = ins.dest_reg;
        res.reg_write_value   = wval;
      end
      if (taken) begin
        res.redirect        = 1'b1;
        res.redirect_target = ins.immediate - 1;
      end
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (want !== got) begin
        $error("Field %s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one delivered result with the oldest expectation.
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("Result delivered with no instruction outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.divide_by_zero) div_zero_seen++;
      if (want.redirect) redirects_seen++;
      if (want.store_valid) stores_seen++;
      compare_field("reg_write_valid", DataW'(want.reg_write_valid),
                    DataW'(got.reg_write_valid));
      compare_field("reg_write_index", DataW'(want.reg_write_index),
                    DataW'(got.reg_write_index));
      compare_field("reg_write_value", want.reg_write_value, got.reg_write_value);
      compare_field("redirect", DataW'(want.redirect), DataW'(got.redirect));
      compare_field("redirect_target", want.redirect_target, got.redirect_target);
      compare_field("store_valid", DataW'(want.store_valid), DataW'(got.store_valid));
      compare_field("store_value", want.store_value, got.store_value);
      compare_field("halted", DataW'(want.halted), DataW'(got.halted));
      compare_field("divide_by_zero", DataW'(want.divide_by_zero),
                    DataW'(got.divide_by_zero));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  bit             calm;
  int             sent;
  exec_scoreboard sb = new();

  rfeu_req_if req_if ();
  rfeu_rsp_if rsp_if ();

  register_file_execute_unit_core u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run must be long over by this time.
  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: check each accepted result, then pick the next ready level.
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      sb.check_result('{reg_write_valid: rsp_if.reg_write_valid,
                        reg_write_index: rsp_if.reg_write_index,
                        reg_write_value: rsp_if.reg_write_value,
                        redirect:        rsp_if.redirect,
                        redirect_target: rsp_if.redirect_target,
                        store_valid:     rsp_if.store_valid,
                        store_value:     rsp_if.store_value,
                        halted:          rsp_if.halted,
                        divide_by_zero:  rsp_if.divide_by_zero});
    end
    rsp_if.ready <= rst_n && (calm || $urandom_range(99) >= IdlePct);
  end

  function automatic instr_t mk(logic [OpW-1:0] op, logic [IdxW-1:0] rd, logic [IdxW-1:0] ra,
                                logic [IdxW-1:0] rb, logic [DataW-1:0] imm,
                                logic [DataW-1:0] ldv);
    instr_t ins;
    ins.opcode     = op;
    ins.dest_reg   = rd;
    ins.src_a_reg  = ra;
    ins.src_b_reg  = rb;
    ins.immediate  = imm;
    ins.load_value = ldv;
    return ins;
  endfunction

  // Operand words lean toward the values where arithmetic and branches turn.
  function automatic logic [DataW-1:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return MinNeg;
      4:       return MaxPos;
      5:       return DataW'(int'($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t rand_instr();
    logic [OpW-1:0] op;
    if ($urandom_range(99) < 4) op = OpW'($urandom_range(int'(OpUnusedLow), int'(OpUnusedTop)));
    else op = OpW'($urandom_range(int'(OpNop), int'(OpHalt)));
    return mk(op, IdxW'($urandom_range(NumRegs - 1)), IdxW'($urandom_range(NumRegs - 1)),
              IdxW'($urandom_range(NumRegs - 1)), rand_word(), rand_word());
  endfunction

  // Offer one request and hold it until the unit takes it.
  task automatic send_instr(instr_t ins);
    int gap;
    gap = (!calm && $urandom_range(99) < IdlePct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= ins.opcode;
    req_if.dest_reg   <= ins.dest_reg;
    req_if.src_a_reg  <= ins.src_a_reg;
    req_if.src_b_reg  <= ins.src_b_reg;
    req_if.immediate  <= ins.immediate;
    req_if.load_value <= ins.load_value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_instr(ins);
    sent++;
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    calm  = 1'b0;
    sent  = 0;
    req_if.valid      <= 1'b0;
    req_if.opcode     <= '0;
    req_if.dest_reg   <= '0;
    req_if.src_a_reg  <= '0;
    req_if.src_b_reg  <= '0;
    req_if.immediate  <= '0;
    req_if.load_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every opcode, overflow and the division corners.
    send_instr(mk(OpLi, 5'd1, 5'd0, 5'd0, MaxPos, '0));
    send_instr(mk(OpLi, 5'd2, 5'd0, 5'd0, MinNeg, '0));
    send_instr(mk(OpLi, 5'd3, 5'd0, 5'd0, '1, '0));
    send_instr(mk(OpLoad, 5'd4, 5'd0, 5'd0, '0, DataW'(-7)));
    send_instr(mk(OpLoad, 5'd31, 5'd31, 5'd31, '1, '1));
    send_instr(mk(OpLi, 5'd5, 5'd0, 5'd0, 32'd3, '1));
    send_instr(mk(OpAdd, 5'd6, 5'd1, 5'd5, '0, '0));
    send_instr(mk(OpSub, 5'd7, 5'd2, 5'd5, '0, '0));
    send_instr(mk(OpMul, 5'd8, 5'd1, 5'd1, '0, '0));
    send_instr(mk(OpDiv, 5'd9, 5'd4, 5'd5, '0, '0));
    // Zero divisor, then the most negative value over minus one.
    send_instr(mk(OpDiv, 5'd10, 5'd1, 5'd0, '0, '0));
    send_instr(mk(OpDiv, 5'd11, 5'd2, 5'd3, '0, '0));
    send_instr(mk(OpInc, 5'd1, 5'd0, 5'd0, '0, '0));
    send_instr(mk(OpDec, 5'd0, 5'd0, 5'd0, '0, '0));
    // Jump to line zero wraps the target to all ones.
    send_instr(mk(OpJump, 5'd0, 5'd0, 5'd0, '0, '0));
    send_instr(mk(OpBeq, 5'd0, 5'd2, 5'd11, 32'd100, '0));
    send_instr(mk(OpBne, 5'd0, 5'd2, 5'd11, 32'd100, '0));
    send_instr(mk(OpBgez, 5'd0, 5'd12, 5'd0, MinNeg, '0));
    send_instr(mk(OpBgtz, 5'd0, 5'd12, 5'd0, 32'd5, '0));
    send_instr(mk(OpBlez, 5'd0, 5'd12, 5'd0, 32'd1, '0));
    send_instr(mk(OpBltz, 5'd0, 5'd3, 5'd0, MaxPos, '0));
    send_instr(mk(OpStore, 5'd0, 5'd31, 5'd0, '0, '0));
    // Halt only flags; the unit keeps executing afterward.
    send_instr(mk(OpHalt, 5'd0, 5'd0, 5'd0, '0, '0));
    send_instr(mk(OpNop, 5'd31, 5'd31, 5'd31, '1, '1));
    send_instr(mk(OpUnusedTop, 5'd31, 5'd31, 5'd31, '1, '1));
    wait_drained();

    // Random: a stretch with both sides always active, then random idling
    // with periodic full drains.
    calm = 1'b1;
    repeat (CalmItems) send_instr(rand_instr());
    calm = 1'b0;
    wait_drained();
    for (int i = 0; i < RandomItems - CalmItems; i++) begin
      send_instr(rand_instr());
      if (i % 300 == 299) wait_drained();
    end
    wait_drained();
    repeat (50) @(posedge clk);

    $display("Executed %0d instructions (%0d directed); %0d results checked.",
             sent, DirectedCnt, sb.checked);
    $display("Among them %0d zero divisors, %0d redirects and %0d stores.",
             sb.div_zero_seen, sb.redirects_seen, sb.stores_seen);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
